// ===== rtl/sqpt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqpt_pkg
// command and status codes and fixed field widths of the stack/queue pair
// ----------------------------------------------------------------------------
package sqpt_pkg;

	localparam int DATA_W = 32;
	localparam int CMD_W  = 2;
	localparam int STS_W  = 2;
	localparam int CNT_W  = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_S2Q    = 2'd1,
		CMD_Q2S    = 2'd2
	} cmd_t;

	typedef enum logic [STS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

endpackage

// ===== rtl/stack_queue_pair_transfer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_queue_pair_transfer_core
// bounded lifo stack and bounded fifo queue of signed words, with insert by
// sign and transfers between the two; one result per command
// ----------------------------------------------------------------------------
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------
//  input    | in_valid / in_stall | command, value
//  output   | out_valid/ out_stall| status, moved_value, stack_count,
//           |                     | queue_count
//
//  a command issues the reads of the stack top and queue head at its transfer
//  edge; once the read stage completes, it writes back and updates counts
//  the read stage is there because the rams have registered read data
//  reset clears the fill counts, the queue head and all valid flags; ram
//  contents stay undefined and are only read where occupied
//  a result waiting in the output register still lets one command in; that
//  command then holds in the read stage and stalls the input until it lands
//
module stack_queue_pair_transfer_core #(
	parameter int STACK_DEPTH = 16,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [sqpt_pkg::CMD_W-1:0]           command,
	input  logic signed [sqpt_pkg::DATA_W-1:0]   value,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [sqpt_pkg::STS_W-1:0]           status,
	output logic signed [sqpt_pkg::DATA_W-1:0]  moved_value,
	output logic [sqpt_pkg::CNT_W-1:0]           stack_count,
	output logic [sqpt_pkg::CNT_W-1:0]           queue_count
);

	import sqpt_pkg::*;

	// address and fill widths
	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int SFW = $clog2(STACK_DEPTH + 1);
	localparam int QAW = $clog2(QUEUE_DEPTH);
	localparam int QFW = $clog2(QUEUE_DEPTH + 1);
	localparam int QSW = QFW + 1;

	// occupancy state
	logic [SFW-1:0] stack_fill_q;
	logic [QFW-1:0] queue_fill_q;
	logic [QAW-1:0] queue_head_q;

	// read stage
	logic              valid_s1;
	logic [CMD_W-1:0]  cmd_s1;
	logic [DATA_W-1:0] val_s1;

	// output register
	logic              out_valid_q;
	logic [STS_W-1:0]  status_q;
	logic [DATA_W-1:0] moved_q;
	logic [CNT_W-1:0]  stack_count_q;
	logic [CNT_W-1:0]  queue_count_q;

	// ram ports
	logic              stk_we;
	logic [SAW-1:0]    stk_waddr;
	logic [SAW-1:0]    stk_raddr;
	logic [DATA_W-1:0] stk_rdata;
	logic              que_we;
	logic [QAW-1:0]    que_waddr;
	logic [DATA_W-1:0] que_wdata;
	logic [DATA_W-1:0] que_rdata;

	logic              in_xfer;
	logic              fin;

	// decode of the command in the read stage
	status_t           sts;
	logic [DATA_W-1:0] moved;
	logic              do_push;
	logic              do_pop;
	logic              do_append;
	logic              do_take;
	logic [DATA_W-1:0] push_data;
	logic              stack_full;
	logic              stack_empty;
	logic              queue_full;
	logic              queue_empty;
	logic [QSW-1:0]    tail_sum;
	logic [QAW-1:0]    tail_addr;
	logic [QAW-1:0]    head_next;
	logic [SFW-1:0]    stack_fill_nx;
	logic [QFW-1:0]    queue_fill_nx;

	// one command in the read stage at a time: the read stage interlocks the rams
	assign in_stall = valid_s1;
	assign in_xfer  = in_valid && !in_stall;
	// the read stage completes once the output register is free or being read out
	assign fin      = valid_s1 && (!out_valid_q || !out_stall);

	assign stack_full  = (stack_fill_q >= SFW'(STACK_DEPTH));
	assign stack_empty = (stack_fill_q == '0);
	assign queue_full  = (queue_fill_q >= QFW'(QUEUE_DEPTH));
	assign queue_empty = (queue_fill_q == '0);

	// queue tail wraps once at most since head stays below the depth and fill does not pass it
	assign tail_sum  = QSW'(queue_head_q) + QSW'(queue_fill_q);
	assign tail_addr = (tail_sum >= QSW'(QUEUE_DEPTH)) ?
		QAW'(tail_sum - QSW'(QUEUE_DEPTH)) : QAW'(tail_sum);
	assign head_next = (queue_head_q == QAW'(QUEUE_DEPTH - 1)) ?
		'0 : queue_head_q + QAW'(1);

	// stack top read address; a read of an empty stack is discarded
	assign stk_raddr = SAW'(stack_fill_q - SFW'(1));

	always_comb begin
		sts       = ST_DONE;
		moved     = '0;
		do_push   = 1'b0;
		do_pop    = 1'b0;
		do_append = 1'b0;
		do_take   = 1'b0;
		push_data = val_s1;
		que_wdata = val_s1;
		unique case (cmd_s1)
			CMD_INSERT: begin
				if (!val_s1[DATA_W-1]) begin
					if (stack_full) begin
						sts = ST_FULL;
					end else begin
						do_push = 1'b1;
						moved   = val_s1;
					end
				end else begin
					if (queue_full) begin
						sts = ST_FULL;
					end else begin
						do_append = 1'b1;
						moved     = val_s1;
					end
				end
			end
			CMD_S2Q: begin
				priority if (stack_empty) begin
					sts = ST_EMPTY;
				end else if (queue_full) begin
					sts = ST_FULL;
				end else begin
					do_pop    = 1'b1;
					do_append = 1'b1;
					moved     = stk_rdata;
					que_wdata = stk_rdata;
				end
			end
			CMD_Q2S: begin
				priority if (queue_empty) begin
					sts = ST_EMPTY;
				end else if (stack_full) begin
					sts = ST_FULL;
				end else begin
					do_take   = 1'b1;
					do_push   = 1'b1;
					moved     = que_rdata;
					push_data = que_rdata;
				end
			end
			default: begin
				// unused code: ignored, reports done with nothing moved
				sts = ST_DONE;
			end
		endcase
	end

	assign stk_we    = fin && do_push;
	assign stk_waddr = SAW'(stack_fill_q);
	assign que_we    = fin && do_append;
	assign que_waddr = tail_addr;

	always_comb begin
		stack_fill_nx = stack_fill_q;
		if (do_push) begin
			stack_fill_nx = stack_fill_q + SFW'(1);
		end else if (do_pop) begin
			stack_fill_nx = stack_fill_q - SFW'(1);
		end
		queue_fill_nx = queue_fill_q;
		if (do_append) begin
			queue_fill_nx = queue_fill_q + QFW'(1);
		end else if (do_take) begin
			queue_fill_nx = queue_fill_q - QFW'(1);
		end
	end

	sqpt_ram #(
		.WIDTH (DATA_W),
		.DEPTH (STACK_DEPTH)
	) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (push_data),
		.re    (in_xfer),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	sqpt_ram #(
		.WIDTH (DATA_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue_ram (
		.clk   (clk),
		.we    (que_we),
		.waddr (que_waddr),
		.wdata (que_wdata),
		.re    (in_xfer),
		.raddr (queue_head_q),
		.rdata (que_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
			stack_fill_q <= '0;
			queue_fill_q <= '0;
			queue_head_q <= '0;
		end else begin
			if (in_xfer) begin
				valid_s1 <= 1'b1;
			end else if (fin) begin
				valid_s1 <= 1'b0;
			end
			if (fin) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (fin) begin
				stack_fill_q <= stack_fill_nx;
				queue_fill_q <= queue_fill_nx;
				if (do_take) begin
					queue_head_q <= head_next;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_s1 <= command;
			val_s1 <= value;
		end
		if (fin) begin
			status_q      <= sts;
			moved_q       <= moved;
			stack_count_q <= CNT_W'(stack_fill_nx);
			queue_count_q <= CNT_W'(queue_fill_nx);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign moved_value = moved_q;
	assign stack_count = stack_count_q;
	assign queue_count = queue_count_q;

	// occupancy never passes the depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(stack_fill_q <= SFW'(STACK_DEPTH)) && (queue_fill_q <= QFW'(QUEUE_DEPTH)))
		else $error("fill count beyond depth");

	// queue head stays a valid index
	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		queue_head_q <= QAW'(QUEUE_DEPTH - 1))
		else $error("queue head out of range");

	// an error result moves nothing
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q != ST_DONE) |-> (moved_q == '0))
		else $error("error result carries a word");

	// a completed command always lands in the output register
	a_fin_out: assert property (@(posedge clk) disable iff (!arst_n)
		fin |=> out_valid_q && !valid_s1)
		else $error("finished command lost");

	// a transfer between stack and queue keeps the total occupancy
	a_xfer_total: assert property (@(posedge clk) disable iff (!arst_n)
		fin && (do_pop || do_take) |=>
		(SFW'(stack_fill_q) + QSW'(queue_fill_q)) ==
		$past(SFW'(stack_fill_q) + QSW'(queue_fill_q)))
		else $error("transfer changed total occupancy");

endmodule

// ===== rtl/sqpt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqpt_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module sqpt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [WIDTH-1:0]           wdata,
	input  logic                       re,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// read data holds until the next read
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== tb/sqpt_pair_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqpt_pair_checker
// watches both channels of the stack/queue pair, keeps its own copy of the
// stack and queue, predicts each result and compares it field by field
// ----------------------------------------------------------------------------
module sqpt_pair_checker #(
	parameter int STACK_DEPTH = 16,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic [sqpt_pkg::CMD_W-1:0]          command,
	input  logic signed [sqpt_pkg::DATA_W-1:0]  value,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic [sqpt_pkg::STS_W-1:0]          status,
	input  logic signed [sqpt_pkg::DATA_W-1:0]  moved_value,
	input  logic [sqpt_pkg::CNT_W-1:0]          stack_count,
	input  logic [sqpt_pkg::CNT_W-1:0]          queue_count,
	output int                                  errors,
	output int                                  pending,
	output int                                  n_results,
	output int                                  n_done,
	output int                                  n_empty,
	output int                                  n_full,
	output int                                  n_both
);
	import sqpt_pkg::*;

	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		status_t                    sts;
		logic signed [DATA_W-1:0]   word;
		logic [CNT_W-1:0]           stk;
		logic [CNT_W-1:0]           que;
	} outcome_t;

	// shadow copy of the block's storage
	logic signed [DATA_W-1:0] stack_words [STACK_DEPTH];
	logic signed [DATA_W-1:0] queue_words [QUEUE_DEPTH];
	int stack_fill;
	int queue_head;
	int queue_fill;

	outcome_t outcome_q [$];
	int err_cnt, res_cnt, done_cnt, empty_cnt, full_cnt, both_cnt;

	function automatic outcome_t run_command(input logic [CMD_W-1:0] cmd,
			input logic signed [DATA_W-1:0] word);
		outcome_t o;
		o.sts  = ST_DONE;
		o.word = '0;
		case (cmd)
		CMD_INSERT: begin
			if (!word[DATA_W-1]) begin
				if (stack_fill >= STACK_DEPTH) begin
					o.sts = ST_FULL;
				end else begin
					stack_words[stack_fill] = word;
					stack_fill++;
					o.word = word;
				end
			end else begin
				if (queue_fill >= QUEUE_DEPTH) begin
					o.sts = ST_FULL;
				end else begin
					queue_words[(queue_head + queue_fill) % QUEUE_DEPTH] = word;
					queue_fill++;
					o.word = word;
				end
			end
		end
		CMD_S2Q: begin
			if (stack_fill == 0) begin
				o.sts = ST_EMPTY;
			end else if (queue_fill >= QUEUE_DEPTH) begin
				o.sts = ST_FULL;
			end else begin
				stack_fill--;
				o.word = stack_words[stack_fill];
				queue_words[(queue_head + queue_fill) % QUEUE_DEPTH] = o.word;
				queue_fill++;
			end
		end
		CMD_Q2S: begin
			if (queue_fill == 0) begin
				o.sts = ST_EMPTY;
			end else if (stack_fill >= STACK_DEPTH) begin
				o.sts = ST_FULL;
			end else begin
				o.word = queue_words[queue_head];
				queue_head = (queue_head + 1) % QUEUE_DEPTH;
				queue_fill--;
				stack_words[stack_fill] = o.word;
				stack_fill++;
			end
		end
		default: ;
		endcase
		o.stk = stack_fill[CNT_W-1:0];
		o.que = queue_fill[CNT_W-1:0];
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			stack_fill = 0;
			queue_head = 0;
			queue_fill = 0;
			outcome_q.delete();
			err_cnt   = 0;
			res_cnt   = 0;
			done_cnt  = 0;
			empty_cnt = 0;
			full_cnt  = 0;
			both_cnt  = 0;
		end else begin
			// results first: a command taken at this edge cannot answer here
			if (out_valid && !out_stall) begin
				res_cnt++;
				if (outcome_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= MAX_REPORTS)
						$display("%0t: result with nothing expected: status %0d value %h",
							$time, status, moved_value);
				end else begin
					want = outcome_q.pop_front();
					case (want.sts)
					ST_DONE:  done_cnt++;
					ST_EMPTY: empty_cnt++;
					default:  full_cnt++;
					endcase
					if (status !== want.sts || moved_value !== want.word ||
							stack_count !== want.stk || queue_count !== want.que) begin
						err_cnt++;
						if (err_cnt <= MAX_REPORTS)
							$display("%0t: expected sts %0d val %h stk %0d que %0d, %s",
								$time, want.sts, want.word, want.stk, want.que,
								$sformatf("got sts %0d val %h stk %0d que %0d",
									status, moved_value, stack_count, queue_count));
					end
				end
			end
			if (in_valid && !in_stall) begin
				if ((command == CMD_S2Q && stack_fill == 0 && queue_fill >= QUEUE_DEPTH) ||
						(command == CMD_Q2S && queue_fill == 0 && stack_fill >= STACK_DEPTH))
					both_cnt++;
				outcome_q.push_back(run_command(command, value));
			end
		end
		errors    <= err_cnt;
		pending   <= outcome_q.size();
		n_results <= res_cnt;
		n_done    <= done_cnt;
		n_empty   <= empty_cnt;
		n_full    <= full_cnt;
		n_both    <= both_cnt;
	end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives commands into the stack/queue pair: a short directed sequence, then
// random bursts that fill, drain and shuttle words between stack and queue,
// with random gaps on the input and random stall on the output; a checker
// beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module tb;
	import sqpt_pkg::*;

	localparam int N_ITEMS        = 1000;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 8;

	// the one command code the block ignores
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef enum int {SIGN_ANY, SIGN_POS, SIGN_NEG} sign_sel_t;
	typedef enum int {
		MODE_FILL_STACK,
		MODE_FILL_QUEUE,
		MODE_TO_QUEUE,
		MODE_TO_STACK,
		MODE_MIXED
	} burst_mode_t;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic [CMD_W-1:0]          command;
	logic signed [DATA_W-1:0]  value;
	logic                      out_valid;
	logic                      out_stall;
	logic [STS_W-1:0]          status;
	logic signed [DATA_W-1:0]  moved_value;
	logic [CNT_W-1:0]          stack_count;
	logic [CNT_W-1:0]          queue_count;

	int errors, pending, n_results, n_done, n_empty, n_full, n_both;

	int n_sent     = 0;   // commands that act on the stack or queue
	int n_ignored  = 0;   // transfers of the unused command
	int idle_cycles = 0;
	bit in_gaps_on = 1'b1;

	// output stall pattern state
	int stall_seg_left = 0;
	int stall_run_left = 0;
	bit stall_calm     = 1'b0;
	int stall_pick;

	// 4 ns clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	stack_queue_pair_transfer_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.moved_value (moved_value),
		.stack_count (stack_count),
		.queue_count (queue_count)
	);

	sqpt_pair_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.moved_value (moved_value),
		.stack_count (stack_count),
		.queue_count (queue_count),
		.errors      (errors),
		.pending     (pending),
		.n_results   (n_results),
		.n_done      (n_done),
		.n_empty     (n_empty),
		.n_full      (n_full),
		.n_both      (n_both)
	);

	// input gap length: mostly back to back, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// data word with a bias toward the sign boundary and the extremes
	function automatic logic [DATA_W-1:0] pick_value(input sign_sel_t sel);
		logic [DATA_W-1:0] w;
		case ($urandom_range(0, 7))
		0:       w = 32'h0000_0000;
		1:       w = 32'h7fff_ffff;
		2:       w = 32'h8000_0000;
		3:       w = 32'hffff_ffff;
		4:       w = $urandom_range(0, 255);
		default: w = $urandom();
		endcase
		if (sel == SIGN_POS)
			w[DATA_W-1] = 1'b0;
		else if (sel == SIGN_NEG)
			w[DATA_W-1] = 1'b1;
		return w;
	endfunction

	// one transfer on the input channel; valid stays high into the next
	// command when there is no gap, so it is never dropped and re-raised
	// within one step
	task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] word);
		int gap;
		gap = in_gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		value    <= word;
		@(posedge clk);
		// payload holds while the block stalls
		while (in_stall)
			@(posedge clk);
		if (cmd == CMD_UNUSED)
			n_ignored++;
		else
			n_sent++;
	endtask

	// a burst, unless mixed, leans toward one kind of command so the stack and queue
	// actually reach full and empty, with a random remainder as noise
	task automatic send_burst(input burst_mode_t mode, input int len);
		logic [CMD_W-1:0]  cmd;
		logic [DATA_W-1:0] word;
		int r;
		for (int k = 0; k < len; k++) begin
			r    = $urandom_range(0, 99);
			word = pick_value(SIGN_ANY);
			if (r < 80 && mode != MODE_MIXED) begin
				case (mode)
				MODE_FILL_STACK: begin
					cmd  = CMD_INSERT;
					word = pick_value(SIGN_POS);
				end
				MODE_FILL_QUEUE: begin
					cmd  = CMD_INSERT;
					word = pick_value(SIGN_NEG);
				end
				MODE_TO_QUEUE: cmd = CMD_S2Q;
				default:       cmd = CMD_Q2S;
				endcase
			end else if (r < 96) begin
				cmd = CMD_W'($urandom_range(CMD_INSERT, CMD_Q2S));
			end else begin
				cmd = CMD_UNUSED;
			end
			send_item(cmd, word);
		end
	endtask

	// output stall: segments that are either calm (never stalled) or
	// broken into runs of stall and go, mostly short with a few long stalls
	always @(posedge clk) begin
		if (stall_seg_left == 0) begin
			stall_seg_left <= $urandom_range(50, 300);
			stall_calm     <= ($urandom_range(0, 3) == 0);
		end else begin
			stall_seg_left <= stall_seg_left - 1;
		end
		if (stall_run_left != 0) begin
			stall_run_left <= stall_run_left - 1;
		end else if (stall_calm) begin
			out_stall <= 1'b0;
		end else begin
			stall_pick = $urandom_range(0, 99);
			if ($urandom_range(0, 2) == 0) begin
				out_stall <= 1'b1;
				if (stall_pick < 60)
					stall_run_left <= $urandom_range(0, 2);
				else if (stall_pick < 90)
					stall_run_left <= $urandom_range(3, 8);
				else
					stall_run_left <= $urandom_range(10, 40);
			end else begin
				out_stall      <= 1'b0;
				stall_run_left <= $urandom_range(0, 5);
			end
		end
	end

	// watchdog: any transfer on either side counts as progress
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("no transfer for %0d cycles, %0d results outstanding",
				WATCHDOG_LIMIT, pending);
			$display("[stack_queue_pair_transfer_core] ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		burst_mode_t mode;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		command   <= CMD_INSERT;
		value     <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: moves out of an empty structure, the ignored command,
		// moves into an empty destination, then the value extremes
		send_item(CMD_S2Q, 32'hffff_ffff);
		send_item(CMD_Q2S, 32'h0000_0000);
		send_item(CMD_UNUSED, 32'hffff_ffff);
		send_item(CMD_INSERT, 32'h0000_0000);
		send_item(CMD_S2Q, 32'h5555_5555);     // lands in an empty queue
		send_item(CMD_Q2S, 32'haaaa_aaaa);     // lands on an empty stack
		send_item(CMD_INSERT, 32'h7fff_ffff);
		send_item(CMD_INSERT, 32'h8000_0000);
		send_item(CMD_INSERT, 32'hffff_ffff);
		send_item(CMD_INSERT, 32'h0000_0001);
		send_item(CMD_INSERT, 32'hc000_0000);
		send_item(CMD_S2Q, 32'h0000_0000);
		send_item(CMD_S2Q, 32'h0000_0000);
		send_item(CMD_Q2S, 32'h0000_0000);
		send_item(CMD_Q2S, 32'h0000_0000);
		send_item(CMD_UNUSED, 32'h0000_0000);
		send_item(CMD_S2Q, 32'h0000_0000);
		send_item(CMD_Q2S, 32'h0000_0000);

		// random bursts, some of them with no input gaps at all
		while (n_sent < N_ITEMS) begin
			mode       = burst_mode_t'($urandom_range(MODE_FILL_STACK, MODE_MIXED));
			in_gaps_on = ($urandom_range(0, 3) != 0);
			send_burst(mode, $urandom_range(10, 40));
		end
		in_valid <= 1'b0;

		// let the checker see the last transfer before polling its count
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("ran %0d commands plus %0d ignored ones, %0d results checked",
			n_sent, n_ignored, n_results);
		$display("statuses: done %0d, source empty %0d, destination full %0d (%0d both)",
			n_done, n_empty, n_full, n_both);
		if (errors == 0 && pending == 0)
			$display("[stack_queue_pair_transfer_core] OK");
		else
			$display("[stack_queue_pair_transfer_core] ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/sqpt_pkg.sv
rtl/sqpt_ram.sv
rtl/stack_queue_pair_transfer_core.sv
tb/sqpt_pair_checker.sv
tb/tb.sv
